[rtl/msort_pkg.sv]
// Shared types and constants for the merge sorter.
package msort_pkg;

    localparam int DATA_WIDTH = 32;

    // Input word: one element of the run.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } in_word_t;

    // Result word: one element in ascending order.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         final_res;
    } out_word_t;

    // Queue word between front and back: element plus end-of-run mark.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         fin;
    } q_word_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

endpackage

[rtl/msort_front.sv]
// Front end: accepts input words, marks run ends, and queues them for the back end.
module msort_front
    import msort_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_word_t item,
    output logic     q_valid,
    input  logic     q_pop,
    output q_word_t  q_word
);

    localparam int CW = $clog2(DEPTH + 1);

    q_word_t          fifo_mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     fill_reg, fill_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push;
    logic             run_end;

    assign item_stall = (fill_reg == (QAW+1)'(QDEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (fill_reg != '0);
    assign q_word     = fifo_mem[rd_ptr_reg];

    // A run ends on the last flag or on the word that fills the store
    assign run_end = item.last || (cnt_reg == CW'(DEPTH - 1));

    always_comb
    begin
        cnt_next    = cnt_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            cnt_next    = run_end ? '0 : cnt_reg + 1'b1;
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{value: item.value, fin: run_end};
        end
    end

endmodule

[rtl/msort_back.sv]
// Back end: loads a run into memory, merge sorts it bottom-up, and emits it in order.
module msort_back
    import msort_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  q_word_t   q_word,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = $clog2(DEPTH + 1) + 2;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_ERD  = 3'd3;
    localparam logic [2:0] S_EOUT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [XW-1:0] n_reg, n_next;
    logic [XW-1:0] w_reg, w_next;
    logic [XW-1:0] mid_reg, mid_next;
    logic [XW-1:0] hi_reg, hi_next;
    logic [XW-1:0] a_reg, a_next;
    logic [XW-1:0] b_reg, b_next;
    logic [XW-1:0] k_reg, k_next;
    logic          src_reg, src_next;
    logic          out_valid_reg, out_valid_next;
    out_word_t     out_reg, out_next;

    logic signed [DATA_WIDTH-1:0] mem0 [DEPTH];
    logic signed [DATA_WIDTH-1:0] mem1 [DEPTH];
    logic signed [DATA_WIDTH-1:0] ra0_reg, rb0_reg, ra1_reg, rb1_reg;
    logic signed [DATA_WIDTH-1:0] rd_a, rd_b;

    logic                         we0, we1;
    logic [AW-1:0]                waddr;
    logic signed [DATA_WIDTH-1:0] wdata;

    logic          setup;
    logic [XW-1:0] set_lo, set_w, set_n, sum_mid, sum_hi;
    logic          take_b;
    logic          out_free;
    logic [XW-1:0] k_inc, w_dbl, n_inc;

    assign rd_a     = src_reg ? ra1_reg : ra0_reg;
    assign rd_b     = src_reg ? rb1_reg : rb0_reg;
    assign out_free = !out_valid_reg || !result_stall;
    assign q_pop    = (state_reg == S_LOAD) && q_valid;
    assign k_inc    = k_reg + 1'b1;
    assign w_dbl    = w_reg << 1;
    assign n_inc    = n_reg + 1'b1;

    // Right-hand run wins ties
    assign take_b = (a_reg >= mid_reg) || ((b_reg < hi_reg) && !(rd_a < rd_b));

    // Run bounds for a new merge
    assign sum_mid = set_lo + set_w;
    assign sum_hi  = set_lo + (set_w << 1);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        w_next         = w_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        we0            = 1'b0;
        we1            = 1'b0;
        waddr          = k_reg[AW-1:0];
        wdata          = take_b ? rd_b : rd_a;
        setup          = 1'b0;
        set_lo         = '0;
        set_w          = w_reg;
        set_n          = n_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (q_valid)
                begin
                    we0    = 1'b1;
                    waddr  = n_reg[AW-1:0];
                    wdata  = q_word.value;
                    n_next = n_inc;
                    if (q_word.fin)
                    begin
                        w_next = XW'(1);
                        if (n_inc == XW'(1))
                        begin
                            a_next     = '0;
                            state_next = S_ERD;
                        end
                        else
                        begin
                            setup      = 1'b1;
                            set_lo     = '0;
                            set_w      = XW'(1);
                            set_n      = n_inc;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                we0        = src_reg;
                we1        = !src_reg;
                state_next = S_RD;
                if (take_b)
                begin
                    b_next = b_reg + 1'b1;
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                end
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (hi_reg == n_reg)
                    begin
                        // Pass complete: swap buffers
                        src_next = !src_reg;
                        w_next   = w_dbl;
                        if (w_dbl >= n_reg)
                        begin
                            a_next     = '0;
                            state_next = S_ERD;
                        end
                        else
                        begin
                            setup  = 1'b1;
                            set_lo = '0;
                            set_w  = w_dbl;
                        end
                    end
                    else
                    begin
                        setup  = 1'b1;
                        set_lo = hi_reg;
                    end
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.sorted_value = rd_a;
                    out_next.final_res    = (a_reg + 1'b1 == n_reg);
                    if (a_reg + 1'b1 == n_reg)
                    begin
                        n_next     = '0;
                        src_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        a_next     = a_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (setup)
        begin
            mid_next = (sum_mid > set_n) ? set_n : sum_mid;
            hi_next  = (sum_hi > set_n) ? set_n : sum_hi;
            a_next   = set_lo;
            b_next   = (sum_mid > set_n) ? set_n : sum_mid;
            k_next   = set_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            n_reg         <= '0;
            w_reg         <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            w_reg         <= w_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Ping-pong buffers, registered reads
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[waddr] <= wdata;
        end
        ra0_reg <= mem0[a_reg[AW-1:0]];
        rb0_reg <= mem0[b_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[waddr] <= wdata;
        end
        ra1_reg <= mem1[a_reg[AW-1:0]];
        rb1_reg <= mem1[b_reg[AW-1:0]];
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[rtl/merge_sorter.sv]
// Merge sorter top level: input queue front end and merge sort back end.
// A run of up to DEPTH signed words goes in, one per cycle while the four-word
// input queue has room; the word flagged last (or the DEPTH-th word) ends the run.
// The back end then sorts with bottom-up merge passes of width 1, 2, 4, ... between
// two ping-pong memories; each merged element takes a registered read, then a
// compare and write. Each sorted word is then read out and emitted in turn, and the
// load takes one queued word per cycle while the queue holds one. Ties keep
// the right-hand run's element first. Words of the next run queue up during a sort.
module merge_sorter
    import msort_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    logic    q_valid;
    logic    q_pop;
    q_word_t q_word;

    msort_front #(.DEPTH(DEPTH)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_word     (q_word)
    );

    msort_back #(.DEPTH(DEPTH)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_word       (q_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // The back end only pops a queued word that is there
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // After the final word of a run is taken, no word follows in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.final_res |=> !result_valid)
        else $error("word emitted right after end of run");

    // A stalled result word stays valid and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

endmodule

[verif/merge_sorter_chk.sv]
// Checker for the merge sorter: watches both channels, predicts sorted runs, compares.
module merge_sorter_chk
    import msort_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_stall,
    input  in_word_t  item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_word_t result,
    output int        fail_count,
    output int        pending
);

    logic signed [DATA_WIDTH-1:0] run_store[$];
    out_word_t                    sorted_words[$];
    int                           mismatches;

    // Bottom-up merge of the current run; ties take the right-hand element.
    task automatic sort_run();
        logic signed [DATA_WIDTH-1:0] buf_a[];
        logic signed [DATA_WIDTH-1:0] buf_b[];
        int n;
        int w;
        int lo;
        int mid;
        int hi;
        int a;
        int b;
        int k;
        out_word_t ow;
        n = run_store.size();
        buf_a = new[n];
        buf_b = new[n];
        foreach (run_store[i]) buf_a[i] = run_store[i];
        for (w = 1; w < n; w = w * 2)
        begin
            for (lo = 0; lo + w < n; lo = lo + 2 * w)
            begin
                mid = lo + w;
                hi = (lo + 2 * w > n) ? n : lo + 2 * w;
                a = lo;
                b = mid;
                k = lo;
                while (a < mid && b < hi)
                begin
                    if (buf_a[a] < buf_a[b]) buf_b[k++] = buf_a[a++];
                    else buf_b[k++] = buf_a[b++];
                end
                while (a < mid) buf_b[k++] = buf_a[a++];
                while (b < hi) buf_b[k++] = buf_a[b++];
                for (k = lo; k < hi; k++) buf_a[k] = buf_b[k];
            end
        end
        for (k = 0; k < n; k++)
        begin
            ow.sorted_value = buf_a[k];
            ow.final_res = (k == n - 1);
            sorted_words.push_back(ow);
        end
        run_store.delete();
    endtask

    assign fail_count = mismatches;
    assign pending = sorted_words.size() + run_store.size();

    // Collect input words; run ends on last or a full store
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_store.delete();
        end
        else if (item_valid && !item_stall)
        begin
            run_store.push_back(item.value);
            if (item.last || run_store.size() == DEPTH) sort_run();
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            mismatches = 0;
            sorted_words.delete();
        end
        else if (result_valid && !result_stall)
        begin
            if (sorted_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value %0d final %0b",
                             result.sorted_value, result.final_res);
            end
            else
            begin
                exp_w = sorted_words.pop_front();
                if (result.sorted_value !== exp_w.sorted_value
                    || result.final_res !== exp_w.final_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b got %0d/%0b",
                                 exp_w.sorted_value, exp_w.final_res,
                                 result.sorted_value, result.final_res);
                end
            end
        end
    end

endmodule

[verif/merge_sorter_tb.sv]
// Testbench top for the merge sorter: stimulus, idling phases and verdict.
module merge_sorter_tb;
    import msort_pkg::*;

    localparam int DEPTH = 64;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_word_t  item;
    logic      result_valid;
    logic      result_stall;
    out_word_t result;
    int        fail_count;
    int        pending;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_cycles;

    merge_sorter #(.DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    merge_sorter_chk #(.DEPTH(DEPTH)) i_chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Receiver stall: random per phase, plus a long counted hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) result_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Random element with frequent extremes and duplicates
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed(32'($urandom_range(3))) - 1;
            default: return $signed($urandom());
        endcase
    endfunction

    // Offer one word and wait for it to be accepted
    task automatic send_word(input logic signed [DATA_WIDTH-1:0] v, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item.value <= v;
        item.last <= lst;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    task automatic send_run(input int n);
        for (int i = 0; i < n; i++) send_word(pick_value(), i == n - 1);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int len;
        int sent;
        rst_n = 0;
        item_valid = 0;
        item = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: single element, extremes, ties, descending
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sh0000_0000, 1'b1);
        for (int i = 0; i < 5; i++) send_word(32'sd5 - i, i == 4);
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b1);
        drain();
        // Full store with no last flag forces the end of the run
        for (int i = 0; i < DEPTH; i++) send_word(pick_value(), 1'b0);
        drain();
        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? 63 : (ph == 3 ? 21 : 0);
            recv_stall_pct = (ph == 2) ? 63 : 0;
            if (ph == 3)
            begin
                send_idle_pct = 21;
                recv_stall_pct = 21;
            end
            if (ph == 0) hold_cycles <= 400;
            for (int r = 0; r < 8; r++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH, 20)
                                               : $urandom_range(8, 1);
                send_run(len);
                sent += len;
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (sent < 250)
        begin
            len = $urandom_range(8, 1);
            send_run(len);
            sent += len;
        end
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0) $display("merge_sorter_tb passed");
        else $display("merge_sorter_tb failed");
        $finish;
    end

    initial
    begin
        #(12 * 2000000);
        $display("merge_sorter_tb failed");
        $finish;
    end

endmodule
